FILE: src/sswq_pkg.sv
// Shared types, result codes and controller/datapath interface structs for the sleep queue.
`default_nettype none

package sswq_pkg;

    localparam int TICK_W            = 63;
    localparam int ID_W              = 8;
    localparam int DUR_W             = 32;
    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int MAX_RESULTS       = 16;
    localparam int WOKE_W            = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] KIND_WOKEN   = 2'd0;
    localparam logic [1:0] KIND_QUEUED  = 2'd1;
    localparam logic [1:0] KIND_IGNORED = 2'd2;
    localparam logic [1:0] KIND_FULL    = 2'd3;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_SLEEP = 1'b1;

    typedef struct packed {
        logic                    mode;
        logic [ID_W-1:0]         thread_id;
        logic signed [DUR_W-1:0] sleep_ticks;
    } t_in;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   woken_id;
        logic [TICK_W-1:0] tick_now;
        logic              last;
    } t_out;

    typedef struct packed {
        logic       load_in;
        logic       ins_start;
        logic       ins_rd;
        logic       ins_move;
        logic       ins_write;
        logic       rd_head;
        logic       pop;
        logic       out_load;
        logic [1:0] out_kind;
        logic       out_last;
        logic       out_pend;
    } t_cmd;

    typedef struct packed {
        logic is_sleep;
        logic dur_bad;
        logic full;
        logic cnt_zero;
        logic rd_gt;
        logic rd_due;
        logic woke_max;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: src/sswq_datapath.sv
// Tick counter, circular sorted queue memory, insert/pop pointers and output register.
`default_nettype none

module sswq_datapath #(
    parameter int QUEUE_DEPTH = sswq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  sswq_pkg::t_in    i_in,
    input  sswq_pkg::t_cmd   i_cmd,
    output sswq_pkg::t_sts   o_sts,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output sswq_pkg::t_out   o_out
);
    import sswq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FULL_CNT = FW'(QUEUE_DEPTH);
    localparam logic [WOKE_W-1:0] WOKE_MAX = WOKE_W'(MAX_RESULTS);

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST_IDX : p - 1'b1;
    endfunction

    logic [TICK_W-1:0] wake_mem [QUEUE_DEPTH];
    logic [ID_W-1:0]   id_mem   [QUEUE_DEPTH];

    logic [TICK_W-1:0] r_tick;
    logic [AW-1:0]     r_head, r_tail, r_wp;
    logic [FW-1:0]     r_fill, r_cnt;
    logic [WOKE_W-1:0] r_woke;
    logic              r_mode, r_dur_bad;
    logic [ID_W-1:0]   r_id, r_pend_id, r_rd_id;
    logic [TICK_W-1:0] r_wake, r_rd_wake;
    logic              r_out_valid;
    t_out              r_out;

    logic              w_rd_en, w_wr_en;
    logic [AW-1:0]     w_rd_addr;
    logic [TICK_W-1:0] w_wr_wake;
    logic [ID_W-1:0]   w_wr_id;

    assign w_rd_en   = i_cmd.rd_head || i_cmd.ins_rd;
    assign w_rd_addr = i_cmd.rd_head ? r_head : idx_dec(r_wp);
    assign w_wr_en   = i_cmd.ins_move || i_cmd.ins_write;
    assign w_wr_wake = i_cmd.ins_move ? r_rd_wake : r_wake;
    assign w_wr_id   = i_cmd.ins_move ? r_rd_id : r_id;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            wake_mem[r_wp] <= w_wr_wake;
            id_mem[r_wp]   <= w_wr_id;
        end
        if (w_rd_en) begin
            r_rd_wake <= wake_mem[w_rd_addr];
            r_rd_id   <= id_mem[w_rd_addr];
        end
    end

    // Payload registers of the incoming transaction, insert walk, popped id and output result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode    <= i_in.mode;
            r_id      <= i_in.thread_id;
            r_dur_bad <= (i_in.sleep_ticks == '0) || i_in.sleep_ticks[DUR_W-1];
            r_wake    <= r_tick + {{(TICK_W-DUR_W){1'b0}}, i_in.sleep_ticks};
        end
        if (i_cmd.ins_start) begin
            r_wp  <= r_tail;
            r_cnt <= r_fill;
        end else if (i_cmd.ins_move) begin
            r_wp  <= idx_dec(r_wp);
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.pop) begin
            r_pend_id <= r_rd_id;
        end
        if (i_cmd.out_load) begin
            r_out.kind     <= i_cmd.out_kind;
            r_out.woken_id <= i_cmd.out_pend ? r_pend_id : r_id;
            r_out.tick_now <= r_tick;
            r_out.last     <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_woke      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                r_woke <= '0;
                if (i_in.mode == MODE_TICK) begin
                    r_tick <= r_tick + 1'b1;
                end
            end
            if (i_cmd.ins_write) begin
                r_tail <= idx_inc(r_tail);
                r_fill <= r_fill + 1'b1;
            end else if (i_cmd.pop) begin
                r_head <= idx_inc(r_head);
                r_fill <= r_fill - 1'b1;
                r_woke <= r_woke + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.is_sleep = (r_mode == MODE_SLEEP);
    assign o_sts.dur_bad  = r_dur_bad;
    assign o_sts.full     = (r_fill == FULL_CNT);
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.rd_gt    = (r_rd_wake > r_wake);
    assign o_sts.rd_due   = (r_rd_wake <= r_tick) && (r_fill != '0);
    assign o_sts.woke_max = (r_woke == WOKE_MAX);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("queue fill above depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_fill != '0)
        else $error("pop from empty queue");
    a_pop_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |=> r_fill == FW'($past(r_fill) - 1'b1))
        else $error("fill did not drop after pop");
    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_write |-> r_fill != FULL_CNT)
        else $error("insert into full queue");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten");

endmodule

`default_nettype wire

FILE: src/sswq_ctrl.sv
// Controller state machine: sequences sorted insert, head pops and result emission.
`default_nettype none

module sswq_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  sswq_pkg::t_sts   i_sts,
    output sswq_pkg::t_cmd   o_cmd
);
    import sswq_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SLEEP    = 4'd1;
    localparam logic [3:0] S_INS_CHK  = 4'd2;
    localparam logic [3:0] S_INS_CMP  = 4'd3;
    localparam logic [3:0] S_INS_DONE = 4'd4;
    localparam logic [3:0] S_TK_RD    = 4'd5;
    localparam logic [3:0] S_TK_CMP   = 4'd6;
    localparam logic [3:0] S_TK_NXT   = 4'd7;
    localparam logic [3:0] S_TK_EMIT  = 4'd8;

    logic [3:0] r_state, n_state;
    logic       w_due_next;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_due_next = i_sts.rd_due && !i_sts.woke_max;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_SLEEP;
                end
            end
            S_SLEEP: begin
                if (!i_sts.is_sleep) begin
                    n_state = S_TK_RD;
                end else if (!i_sts.dur_bad && !i_sts.full) begin
                    o_cmd.ins_start = 1'b1;
                    n_state         = S_INS_CHK;
                end else if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = i_sts.dur_bad ? KIND_IGNORED : KIND_FULL;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_INS_CHK: begin
                if (i_sts.cnt_zero) begin
                    o_cmd.ins_write = 1'b1;
                    n_state         = S_INS_DONE;
                end else begin
                    o_cmd.ins_rd = 1'b1;
                    n_state      = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                // shift later entries one slot toward the tail, else write the new entry into the gap
                if (i_sts.rd_gt) begin
                    o_cmd.ins_move = 1'b1;
                    n_state        = S_INS_CHK;
                end else begin
                    o_cmd.ins_write = 1'b1;
                    n_state         = S_INS_DONE;
                end
            end
            S_INS_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = KIND_QUEUED;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_TK_RD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_TK_CMP;
            end
            S_TK_CMP: begin
                if (i_sts.rd_due) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_TK_NXT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TK_NXT: begin
                // look at the new head so the pending result knows if it is last
                o_cmd.rd_head = 1'b1;
                n_state       = S_TK_EMIT;
            end
            S_TK_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = KIND_WOKEN;
                    o_cmd.out_pend = 1'b1;
                    o_cmd.out_last = !w_due_next;
                    if (w_due_next) begin
                        o_cmd.pop = 1'b1;
                        n_state   = S_TK_NXT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_one_mem_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.ins_rd, o_cmd.rd_head, o_cmd.ins_move, o_cmd.ins_write}) <= 1)
        else $error("conflicting queue memory commands");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_in |=> r_state == S_SLEEP)
        else $error("transaction taken outside idle");
    a_pop_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.pop && (o_cmd.ins_write || o_cmd.ins_move)))
        else $error("pop during insert");

endmodule

`default_nettype wire

FILE: src/sorted_sleep_wakeup_queue.sv
// Top level of the sorted sleep/wake-up queue: controller plus datapath.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_stall      | i_in  (mode, thread_id, sleep_ticks)
//  out     | output    | o_out_valid / i_out_stall    | o_out (kind, woken_id, tick_now, last)
//
// A sleep request is inserted by a walk from the tail that moves each later entry one slot
// toward the tail; ignored or full requests skip the walk.
// A tick pops every due thread from the head, at most 16 per tick.
// Reset clears the counter and the queue pointers; the queue memory needs no clearing.
// Results sit in an output register, so a new transaction is taken while one waits;
// a stalled output holds the controller only when the next result is ready.
`default_nettype none

module sorted_sleep_wakeup_queue #(
    parameter int QUEUE_DEPTH = sswq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_stall,
    input  sswq_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  wire             i_out_stall,
    output sswq_pkg::t_out  o_out
);
    import sswq_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    sswq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sswq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

FILE: verif/sorted_sleep_wakeup_queue_tb.sv
// Self-checking testbench for the sorted sleep/wake-up queue: directed table, then random traffic.
`default_nettype none

module sorted_sleep_wakeup_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sswq_pkg::*;

    localparam int DEPTH        = QUEUE_DEPTH_DEF;
    localparam int PHASE_ITEMS  = 101;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_PRINTS   = 40;

    typedef enum int {PH_STEADY, PH_SEND_GAPS, PH_RECV_STALLS, PH_BOTH} t_phase;

    typedef struct {
        t_in  item;
        int   reps;
        bit   typed;
        t_out want;
    } t_row;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_item   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_item;

    t_phase phase = PH_STEADY;
    int     mismatches = 0;
    int     results_seen = 0;

    // shadow of the block's state
    logic [TICK_W-1:0] now_ticks;
    logic [TICK_W-1:0] wake_at [DEPTH];
    logic [ID_W-1:0]   sleeper [DEPTH];
    int                fill;

    t_out step_results [$];
    t_out pending_results [$];
    t_row stim_table [$];

    sorted_sleep_wakeup_queue #(.QUEUE_DEPTH(DEPTH)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic t_out make_result(logic [1:0] kind, logic [ID_W-1:0] id,
                                         logic [TICK_W-1:0] now, logic last);
        t_out r;
        r.kind     = kind;
        r.woken_id = id;
        r.tick_now = now;
        r.last     = last;
        return r;
    endfunction

    // Apply one transaction to the shadow queue and collect what it should produce.
    function automatic void advance_sleep_queue(t_in item);
        logic [TICK_W-1:0] wake;
        int pos;
        int n;
        step_results.delete();
        if (item.mode == MODE_SLEEP) begin
            if (item.sleep_ticks[DUR_W-1] || item.sleep_ticks == '0) begin
                step_results.push_back(make_result(KIND_IGNORED, item.thread_id, now_ticks, 1'b1));
            end else if (fill >= DEPTH) begin
                step_results.push_back(make_result(KIND_FULL, item.thread_id, now_ticks, 1'b1));
            end else begin
                wake = now_ticks + {{(TICK_W-DUR_W){1'b0}}, item.sleep_ticks};
                pos = 0;
                // equal wake ticks keep arrival order
                while (pos < fill && wake_at[pos] <= wake) pos++;
                for (int i = fill; i > pos; i--) begin
                    wake_at[i] = wake_at[i-1];
                    sleeper[i] = sleeper[i-1];
                end
                wake_at[pos] = wake;
                sleeper[pos] = item.thread_id;
                fill++;
                step_results.push_back(make_result(KIND_QUEUED, item.thread_id, now_ticks, 1'b1));
            end
        end else begin
            now_ticks = now_ticks + 1'b1;
            n = 0;
            while (n < MAX_RESULTS && fill > 0 && wake_at[0] <= now_ticks) begin
                step_results.push_back(make_result(KIND_WOKEN, sleeper[0], now_ticks, 1'b0));
                for (int i = 1; i < fill; i++) begin
                    wake_at[i-1] = wake_at[i];
                    sleeper[i-1] = sleeper[i];
                end
                fill--;
                n++;
            end
            if (n > 0) step_results[n-1].last = 1'b1;
        end
    endfunction

    function automatic void add_row(logic mode, logic [ID_W-1:0] id, logic [DUR_W-1:0] dur,
                                    int reps, bit typed, logic [1:0] kind,
                                    logic [TICK_W-1:0] now);
        t_row row;
        row.item.mode        = mode;
        row.item.thread_id   = id;
        row.item.sleep_ticks = dur;
        row.reps             = reps;
        row.typed            = typed;
        row.want             = make_result(kind, id, now, 1'b1);
        stim_table.push_back(row);
    endfunction

    function automatic t_in random_item();
        t_in it;
        int unsigned pick;
        it.mode        = MODE_TICK;
        it.thread_id   = ID_W'($urandom);
        it.sleep_ticks = $urandom;
        if ($urandom_range(99) >= 48) begin
            it.mode = MODE_SLEEP;
            pick = $urandom_range(99);
            if (pick < 3)
                it.sleep_ticks = '0;
            else if (pick < 10)
                it.sleep_ticks = $urandom | 32'h8000_0000;
            else if (pick == 10)
                it.sleep_ticks = {1'b0, 31'($urandom)};
            else
                it.sleep_ticks = $urandom_range(24, 1);
        end
        return it;
    endfunction

    function automatic int idle_pct(t_phase ph, bit recv_side);
        case (ph)
            PH_SEND_GAPS:   return recv_side ? 0 : 50;
            PH_RECV_STALLS: return recv_side ? 50 : 0;
            PH_BOTH:        return 36;
            default:        return 0;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t ns: %s: expected 'h%0h, got 'h%0h", $time, what, want, got);
    endtask

    // Offer one transaction, hold it until taken, then queue what it should produce.
    task automatic drive_item(t_in item, bit typed, t_out want);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct(phase, 1'b0)) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (in_stall);
        advance_sleep_queue(item);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (step_results[i]) pending_results.push_back(step_results[i]);
    endtask

    // receiver: one long hold-off at the start of the stall phase, then random stalls
    initial begin
        bit pressure_done;
        pressure_done = 1'b0;
        forever begin
            @(negedge clk);
            if (phase == PH_RECV_STALLS && !pressure_done) begin
                pressure_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else begin
                out_stall <= ($urandom_range(99) < idle_pct(phase, 1'b1));
            end
        end
    end

    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with none pending, id", '0, 64'(out_item.woken_id));
            end else begin
                want = pending_results.pop_front();
                if (out_item.kind !== want.kind)
                    report_mismatch($sformatf("result %0d kind", results_seen),
                                    64'(want.kind), 64'(out_item.kind));
                if (out_item.woken_id !== want.woken_id)
                    report_mismatch($sformatf("result %0d woken_id", results_seen),
                                    64'(want.woken_id), 64'(out_item.woken_id));
                if (out_item.tick_now !== want.tick_now)
                    report_mismatch($sformatf("result %0d tick_now", results_seen),
                                    64'(want.tick_now), 64'(out_item.tick_now));
                if (out_item.last !== want.last)
                    report_mismatch($sformatf("result %0d last", results_seen),
                                    64'(want.last), 64'(out_item.last));
            end
            results_seen++;
        end
    end

    initial begin
        #4_000_000;
        $display("sorted_sleep_wakeup_queue_tb: errors");
        $finish;
    end

    initial begin
        t_in  item;
        t_out want;
        now_ticks = '0;
        fill      = 0;

        // non-positive durations, including both sign extremes
        add_row(MODE_SLEEP, 8'h00, 32'h0000_0000, 1, 1'b1, KIND_IGNORED, 63'd0);
        add_row(MODE_SLEEP, 8'hFF, 32'hFFFF_FFFF, 1, 1'b1, KIND_IGNORED, 63'd0);
        add_row(MODE_SLEEP, 8'h5A, 32'h8000_0000, 1, 1'b1, KIND_IGNORED, 63'd0);
        // tick with nothing due; the other fields are don't-care
        add_row(MODE_TICK,  8'hFF, 32'h7FFF_FFFF, 1, 1'b0, KIND_WOKEN, 63'd0);
        add_row(MODE_SLEEP, 8'hA5, 32'h7FFF_FFFF, 1, 1'b1, KIND_QUEUED, 63'd1);
        add_row(MODE_SLEEP, 8'h01, 32'd1, 1, 1'b1, KIND_QUEUED, 63'd1);
        add_row(MODE_SLEEP, 8'h02, 32'd1, 1, 1'b1, KIND_QUEUED, 63'd1);
        add_row(MODE_SLEEP, 8'h04, 32'd2, 1, 1'b1, KIND_QUEUED, 63'd1);
        // equal wake ticks, filling the queue up to the limit
        add_row(MODE_SLEEP, 8'h10, 32'd3, 12, 1'b0, KIND_QUEUED, 63'd0);
        add_row(MODE_SLEEP, 8'h77, 32'd1, 1, 1'b1, KIND_FULL, 63'd1);
        add_row(MODE_SLEEP, 8'h78, 32'd0, 1, 1'b1, KIND_IGNORED, 63'd1);
        // drain: two at once, one, then twelve at once
        add_row(MODE_TICK,  8'h00, 32'd0, 3, 1'b0, KIND_WOKEN, 63'd0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[r]) begin
            for (int k = 0; k < stim_table[r].reps; k++) begin
                item = stim_table[r].item;
                if (item.mode == MODE_SLEEP) item.thread_id = item.thread_id + ID_W'(k);
                drive_item(item, stim_table[r].typed, stim_table[r].want);
            end
        end

        want = '0;
        for (int p = PH_STEADY; p <= PH_BOTH; p++) begin
            phase = t_phase'(p);
            repeat (PHASE_ITEMS) drive_item(random_item(), 1'b0, want);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        foreach (pending_results[i])
            report_mismatch("result never arrived, id", 64'(pending_results[i].woken_id), '0);

        if (mismatches == 0)
            $display("sorted_sleep_wakeup_queue_tb: clean");
        else
            $display("sorted_sleep_wakeup_queue_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
src/sswq_pkg.sv
src/sswq_datapath.sv
src/sswq_ctrl.sv
src/sorted_sleep_wakeup_queue.sv
verif/sorted_sleep_wakeup_queue_tb.sv
